// ===== sv/mma17_pkg.sv =====
// Shared constants and types for the mirrored moving-average block.
`timescale 1ns / 1ps

package mma17_pkg;

  localparam int WINDOW_LENGTH = 17;
  localparam int SAMPLE_BITS   = 16;
  localparam int HALF          = (WINDOW_LENGTH - 1) / 2;
  localparam int FRAC_BITS     = 4;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRAC_BITS;

  localparam int ADDR_BITS = $clog2(WINDOW_LENGTH);
  localparam int CNT_BITS  = $clog2(WINDOW_LENGTH + 1);
  localparam int IDX_BITS  = $clog2(2 * WINDOW_LENGTH);
  localparam int TAIL_BITS = $clog2(HALF + 1);

  // A window sum needs SAMPLE_BITS plus the growth of WINDOW_LENGTH terms.
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam int MAG_BITS = SUM_BITS - 1 + FRAC_BITS;

  // Division by the window length is a multiply by a scaled reciprocal.
  localparam int RECIP_SHIFT = MAG_BITS + 4;
  localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(WINDOW_LENGTH + 1) + 1;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
  localparam int Q_BITS      = PROD_BITS - RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / WINDOW_LENGTH);

  typedef enum logic [1:0] {
    OP_START,   // first sample of a record: sum is twice the sample
    OP_DOUBLE,  // head sample: it appears twice in the first window
    OP_ADD,     // first window: add the incoming sample only
    OP_SLIDE    // add the incoming sample, drop the outgoing one
  } sum_op_t;

  typedef struct packed {
    logic    act;
    logic    emit;
    logic    final_m;
    logic    short_r;
    sum_op_t op;
    logic    ram_in;
  } issue_ctrl_t;

endpackage

// ===== sv/mma17_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mma17_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Reads return the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== sv/mirrored_moving_average_17_core.sv =====
// Top level of the mirrored centered moving average over 17 samples.
// Usage:
//   Samples of a record enter on in_sample_value with in_record_end on the
//   last one; both channels use valid/ready transfers. For each record
//   position one 17-sample centered mean leaves on out_mean_value (signed,
//   4 fraction bits, truncated toward zero). Mean t leaves once sample t+8
//   has arrived; the record ends are mirrored.
//   Throughput: one sample per cycle while in_ready is high. A sample
//   that ends a record of at least 8 samples yields up to 9 means;
//   in_ready stays low while the 8 tail means are read back from the sample RAM.
//   A record shorter than 8 samples yields one result with short_record
//   and final_mean set and a mean of zero.
//   Pipeline: the transfer that causes a mean passes through registers
//   for the RAM read, sum update, reciprocal multiply and correction.
//   Reset clears the counters and the pipeline; the sample RAM is not
//   cleared, and only entries of the current record are ever read.
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops in the same cycle.
`timescale 1ns / 1ps

module mirrored_moving_average_17_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mma17_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic                                   in_record_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mma17_pkg::MEAN_BITS-1:0] out_mean_value,
  output logic                                   out_final_mean,
  output logic                                   out_short_record
);

  import mma17_pkg::*;

  localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(WINDOW_LENGTH);
  localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(WINDOW_LENGTH - 1);
  localparam logic [CNT_BITS-1:0]  CNT_HALF  = CNT_BITS'(HALF);
  localparam logic [CNT_BITS-1:0]  CNT_HALF1 = CNT_BITS'(HALF - 1);
  localparam logic [CNT_BITS-1:0]  CNT_ZERO  = CNT_BITS'(0);
  localparam logic [CNT_BITS-1:0]  CNT_ONE   = CNT_BITS'(1);
  localparam logic [ADDR_BITS-1:0] ADDR_TOP  = ADDR_BITS'(WINDOW_LENGTH - 1);
  localparam logic [ADDR_BITS-1:0] ADDR_ZERO = ADDR_BITS'(0);
  localparam logic [ADDR_BITS-1:0] ADDR_ONE  = ADDR_BITS'(1);
  localparam logic [IDX_BITS-1:0]  IDX_W     = IDX_BITS'(WINDOW_LENGTH);
  localparam logic [IDX_BITS-1:0]  IDX_W1    = IDX_BITS'(WINDOW_LENGTH + 1);
  localparam logic [IDX_BITS-1:0]  IDX_H1    = IDX_BITS'(HALF + 1);
  localparam logic [IDX_BITS-1:0]  IDX_ONE   = IDX_BITS'(1);
  localparam logic [TAIL_BITS-1:0] TAIL_ONE  = TAIL_BITS'(1);
  localparam logic [TAIL_BITS-1:0] TAIL_LAST = TAIL_BITS'(HALF);
  localparam logic [MAG_BITS-1:0]  MAG_W     = MAG_BITS'(WINDOW_LENGTH);

  // Record tracking and tail flush.
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0] wptr_r, wptr_nxt;
  logic                 tail_r, tail_nxt;
  logic [TAIL_BITS-1:0] tail_j_r, tail_j_nxt;

  logic adv;
  logic in_xfer;
  logic tail_go;

  logic [CNT_BITS-1:0]  cnt_inc;
  logic [ADDR_BITS-1:0] wptr_inc;

  logic [IDX_BITS-1:0]  wptr_ext, n_ext, j_ext, in_tmp, out_tmp, nj_sum;
  logic [ADDR_BITS-1:0] raddr_a, raddr_b;

  // Issue stage and RAM read data.
  issue_ctrl_t st1_nxt, st1_r;
  logic signed [SAMPLE_BITS-1:0] st1_sample_r;
  logic [SAMPLE_BITS-1:0] rdata_a, rdata_b;

  // Running window sum.
  logic signed [SUM_BITS-1:0]    sum_r;
  logic signed [SAMPLE_BITS-1:0] inc_sample;
  logic signed [SUM_BITS-1:0]    inc_ext, outg_ext, sum_calc;

  // Divide pipeline.
  logic                       v2_r, fin2_r, short2_r;
  logic signed [SUM_BITS-1:0] sum2_r;
  logic [SUM_BITS-1:0]        sum2_abs;
  logic [MAG_BITS-1:0]        mag2;
  logic                       v3_r, fin3_r, short3_r, neg3_r;
  logic [MAG_BITS-1:0]        mag3_r;
  logic [PROD_BITS-1:0]       prod3_r;
  logic [Q_BITS-1:0]          q0, q;
  logic [MAG_BITS-1:0]        rem;
  logic [MEAN_BITS-1:0]       mean_mag, mean_nxt;

  logic                        out_valid_r;
  logic signed [MEAN_BITS-1:0] out_mean_r;
  logic                        out_final_r, out_short_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !tail_r;
  assign in_xfer  = in_valid && in_ready;
  assign tail_go  = adv && tail_r;

  assign cnt_inc  = (cnt_r == CNT_FULL) ? cnt_r : cnt_r + CNT_ONE;
  assign wptr_inc = (wptr_r == ADDR_TOP) ? ADDR_ZERO : wptr_r + ADDR_ONE;

  // Tail step j reads sample n-j as the incoming term and sample n-18+j
  // (or its mirror before the record start) as the outgoing term.
  always_comb begin
    wptr_ext = IDX_BITS'(wptr_r);
    n_ext    = IDX_BITS'(cnt_r);
    j_ext    = IDX_BITS'(tail_j_r);
    in_tmp   = wptr_ext + IDX_W - j_ext;
    out_tmp  = wptr_ext + j_ext - IDX_ONE;
    nj_sum   = n_ext + j_ext;
  end

  always_comb begin
    raddr_a = ADDR_ZERO;
    raddr_b = ADDR_ZERO;
    if (tail_r) begin
      raddr_a = (in_tmp >= IDX_W) ? ADDR_BITS'(in_tmp - IDX_W) : ADDR_BITS'(in_tmp);
      if (nj_sum < IDX_W1) begin
        raddr_b = ADDR_BITS'(IDX_W - nj_sum);
      end else if (out_tmp >= IDX_W) begin
        raddr_b = ADDR_BITS'(out_tmp - IDX_W);
      end else begin
        raddr_b = ADDR_BITS'(out_tmp);
      end
    end else if (cnt_r < CNT_FULL) begin
      // Before the ring wraps, the dropped sample is a mirrored head sample.
      raddr_b = ADDR_BITS'(CNT_LAST - cnt_r);
    end else begin
      raddr_b = wptr_r;
    end
  end

  mma17_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_LENGTH)
  ) u_ram (
    .clk    (clk),
    .we     (in_xfer),
    .waddr  (wptr_r),
    .wdata  (in_sample_value),
    .re     (adv),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // Issue decision for this cycle.
  always_comb begin
    st1_nxt = '{act: 1'b0, emit: 1'b0, final_m: 1'b0, short_r: 1'b0,
                op: OP_SLIDE, ram_in: 1'b0};
    if (in_xfer) begin
      st1_nxt.act = 1'b1;
      if (cnt_r == CNT_ZERO) begin
        st1_nxt.op = OP_START;
      end else if (cnt_r < CNT_HALF) begin
        st1_nxt.op = OP_DOUBLE;
      end else if (cnt_r == CNT_HALF) begin
        st1_nxt.op = OP_ADD;
      end else begin
        st1_nxt.op = OP_SLIDE;
      end
      st1_nxt.short_r = in_record_end && (cnt_r < CNT_HALF1);
      st1_nxt.final_m = st1_nxt.short_r;
      st1_nxt.emit    = st1_nxt.short_r || (cnt_r >= CNT_HALF);
    end else if (tail_go) begin
      st1_nxt.act     = 1'b1;
      st1_nxt.emit    = 1'b1;
      st1_nxt.ram_in  = 1'b1;
      st1_nxt.final_m = (tail_j_r == TAIL_LAST);
      // The first tail step of a record of exactly HALF samples has no
      // outgoing term.
      st1_nxt.op      = (nj_sum == IDX_H1) ? OP_ADD : OP_SLIDE;
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    wptr_nxt   = wptr_r;
    tail_nxt   = tail_r;
    tail_j_nxt = tail_j_r;
    if (in_xfer) begin
      if (in_record_end && (cnt_r < CNT_HALF1)) begin
        cnt_nxt  = CNT_ZERO;
        wptr_nxt = ADDR_ZERO;
      end else begin
        cnt_nxt  = cnt_inc;
        wptr_nxt = wptr_inc;
        if (in_record_end) begin
          tail_nxt   = 1'b1;
          tail_j_nxt = TAIL_ONE;
        end
      end
    end else if (tail_go) begin
      if (tail_j_r == TAIL_LAST) begin
        tail_nxt = 1'b0;
        cnt_nxt  = CNT_ZERO;
        wptr_nxt = ADDR_ZERO;
      end else begin
        tail_j_nxt = tail_j_r + TAIL_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CNT_ZERO;
      wptr_r   <= ADDR_ZERO;
      tail_r   <= 1'b0;
      tail_j_r <= TAIL_ONE;
      st1_r    <= '{act: 1'b0, emit: 1'b0, final_m: 1'b0, short_r: 1'b0,
                    op: OP_SLIDE, ram_in: 1'b0};
    end else begin
      cnt_r    <= cnt_nxt;
      wptr_r   <= wptr_nxt;
      tail_r   <= tail_nxt;
      tail_j_r <= tail_j_nxt;
      if (adv) begin
        st1_r <= st1_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st1_sample_r <= in_sample_value;
    end
  end

  // Running sum update, one window step per cycle unless the output stalls.
  always_comb begin
    inc_sample = st1_r.ram_in ? $signed(rdata_a) : st1_sample_r;
    inc_ext    = SUM_BITS'(inc_sample);
    outg_ext   = SUM_BITS'($signed(rdata_b));
    case (st1_r.op)
      OP_START:  sum_calc = inc_ext <<< 1;
      OP_DOUBLE: sum_calc = sum_r + (inc_ext <<< 1);
      OP_ADD:    sum_calc = sum_r + inc_ext;
      OP_SLIDE:  sum_calc = sum_r + inc_ext - outg_ext;
      default:   sum_calc = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && st1_r.act) begin
      sum_r <= sum_calc;
    end
    if (adv) begin
      sum2_r   <= st1_r.short_r ? '0 : sum_calc;
      fin2_r   <= st1_r.final_m;
      short2_r <= st1_r.short_r;
    end
  end

  // Magnitude times the reciprocal of the window length.
  always_comb begin
    sum2_abs = sum2_r[SUM_BITS-1] ? SUM_BITS'(-sum2_r) : SUM_BITS'(sum2_r);
    mag2     = {sum2_abs[SUM_BITS-2:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg3_r   <= sum2_r[SUM_BITS-1];
      mag3_r   <= mag2;
      prod3_r  <= PROD_BITS'(mag2) * PROD_BITS'(RECIP);
      fin3_r   <= fin2_r;
      short3_r <= short2_r;
    end
  end

  // The reciprocal quotient is at most one low; one compare fixes it.
  always_comb begin
    q0       = prod3_r[PROD_BITS-1 -: Q_BITS];
    rem      = mag3_r - MAG_BITS'(q0) * MAG_W;
    q        = q0 + Q_BITS'(rem >= MAG_W);
    mean_mag = MEAN_BITS'(q);
    mean_nxt = neg3_r ? MEAN_BITS'(-mean_mag) : mean_mag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mean_r  <= mean_nxt;
      out_final_r <= fin3_r;
      out_short_r <= short3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v2_r        <= st1_r.emit;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_value   = out_mean_r;
  assign out_final_mean   = out_final_r;
  assign out_short_record = out_short_r;

`ifndef ASSERT_OFF
  a_tail_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> (tail_j_r >= TAIL_ONE) && (tail_j_r <= TAIL_LAST))
    else $error("tail step counter out of range");

  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tail_r) |-> (cnt_r >= CNT_HALF))
    else $error("tail flush started without a full head");

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r <= ADDR_TOP) && (cnt_r <= CNT_FULL))
    else $error("ring pointer or sample count out of range");

  a_short_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_record |-> out_final_mean)
    else $error("short record result not marked final");

  a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(sum_r) && $stable(st1_r))
    else $error("window sum moved during an output stall");
`endif

endmodule

// ===== test/mirrored_moving_average_17_core_tb.sv =====
// Self-checking testbench for the mirrored 17-sample centered moving average.
`timescale 1ns / 1ps

module mirrored_moving_average_17_core_tb;
  import mma17_pkg::*;

  localparam int RANDOM_ITEMS = 325;
  localparam int CALM_FROM    = 280;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean;
    logic                 fin;
    logic                 shrt;
  } mean_rec_t;

  // One stimulus row. Where typed is set, the row yields n_means results of
  // the given mean, the last one marked final when the row ends the record.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    bit                            typed;
    int                            n_means;
    logic [MEAN_BITS-1:0]          mean;
    logic                          shrt;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_value;
  logic                          in_record_end;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [MEAN_BITS-1:0]   out_mean_value;
  logic                          out_final_mean;
  logic                          out_short_record;

  // Typed expectation that travels with the sample on the input channel.
  bit                   cur_typed;
  int                   cur_count;
  logic [MEAN_BITS-1:0] cur_mean;
  logic                 cur_short;

  bit calm;
  int cycle_cnt;
  int mismatches;
  int quiet_cycles;

  mean_rec_t expected_means[$];
  mean_rec_t fresh_means[$];
  stim_row_t dir_rows[$];

  // Predictor state.
  logic signed [SAMPLE_BITS-1:0] win_hist[WINDOW_LENGTH];
  logic signed [SAMPLE_BITS-1:0] head_hist[HALF];
  int                            seen_cnt;

  mirrored_moving_average_17_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .in_record_end    (in_record_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_value   (out_mean_value),
    .out_final_mean   (out_final_mean),
    .out_short_record (out_short_record)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Sample at back-offset b from the newest one, mirrored at both record ends.
  function automatic longint tap(int b, int cnt);
    int bb;
    int h;
    bb = b;
    if (bb < 0) bb = -bb - 1;
    if (bb >= cnt) begin
      h = bb - cnt;
      if (h < 0 || h >= HALF) return 0;
      return longint'(head_hist[h]);
    end
    if (bb >= WINDOW_LENGTH) return 0;
    return longint'(win_hist[bb]);
  endfunction

  // Mean of the window centered d samples behind the newest sample.
  function automatic logic [MEAN_BITS-1:0] mean_around(int d, int cnt);
    longint acc;
    int     k;
    acc = 0;
    for (k = -HALF; k < WINDOW_LENGTH - HALF; k++) acc += tap(d - k, cnt);
    acc = (acc * 16) / WINDOW_LENGTH;
    return acc[MEAN_BITS-1:0];
  endfunction

  task automatic slide_window(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    int i;
    int d;
    fresh_means.delete();
    for (i = WINDOW_LENGTH - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
    win_hist[0] = s;
    if (seen_cnt < HALF) head_hist[seen_cnt] = s;
    if (seen_cnt < WINDOW_LENGTH) seen_cnt++;
    if (!last) begin
      if (seen_cnt >= HALF + 1) fresh_means.push_back({mean_around(HALF, seen_cnt), 2'b00});
    end else begin
      if (seen_cnt < HALF) begin
        fresh_means.push_back({{MEAN_BITS{1'b0}}, 2'b11});
      end else begin
        if (seen_cnt >= HALF + 1)
          fresh_means.push_back({mean_around(HALF, seen_cnt), 2'b00});
        for (d = HALF - 1; d >= 0; d--)
          fresh_means.push_back({mean_around(d, seen_cnt), d == 0, 1'b0});
      end
      seen_cnt = 0;
    end
  endtask

  task automatic add_row(logic signed [SAMPLE_BITS-1:0] s, logic last, bit typed,
                         int n, logic [MEAN_BITS-1:0] m, logic shrt);
    stim_row_t r;
    r.sample  = s;
    r.last    = last;
    r.typed   = typed;
    r.n_means = n;
    r.mean    = m;
    r.shrt    = shrt;
    dir_rows.push_back(r);
  endtask

  task automatic send_item(stim_row_t r, bit allow_idle);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_sample_value = r.sample;
    in_record_end   = r.last;
    cur_typed       = r.typed;
    cur_count       = r.n_means;
    cur_mean        = r.mean;
    cur_short       = r.shrt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Output check first, then prediction: a mean never leaves in the cycle of
  // the transfer that causes it.
  always @(posedge clk) begin
    mean_rec_t got;
    mean_rec_t want;
    int        i;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_mean_value, out_final_mean, out_short_record};
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected mean %0d final %0b short %0b", $signed(got.mean),
                     got.fin, got.shrt);
        end else begin
          want = expected_means.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: expected mean %0d final %0b short %0b, got %0d %0b %0b",
                       $signed(want.mean), want.fin, want.shrt, $signed(got.mean),
                       got.fin, got.shrt);
          end
        end
      end
      if (in_valid && in_ready) begin
        slide_window(in_sample_value, in_record_end);
        if (cur_typed) begin
          for (i = 0; i < cur_count; i++)
            expected_means.push_back({cur_mean, in_record_end && (i == cur_count - 1),
                                      cur_short});
        end else begin
          foreach (fresh_means[i]) expected_means.push_back(fresh_means[i]);
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("FAIL mirrored_moving_average_17_core");
          $finish;
        end
      end
    end
  end

  // Receiver: stalls in bursts, with stretches of no stall and none at the end.
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!calm && ((cycle_cnt / 150) % 3 != 2) && $urandom_range(0, 4) == 0)
          hold = $urandom_range(1, 4);
      end
    end
  end

  initial begin
    stim_row_t r;
    int        idx;
    int        rnd_count;
    int        rec_left;
    int        pick;
    int        i;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_record_end   = 1'b0;
    cur_typed       = 1'b0;
    cur_count       = 0;
    cur_mean        = '0;
    cur_short       = 1'b0;
    calm            = 1'b0;
    cycle_cnt       = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    seen_cnt        = 0;
    for (i = 0; i < WINDOW_LENGTH; i++) win_hist[i] = '0;
    for (i = 0; i < HALF; i++) head_hist[i] = '0;

    // A one-sample record, then a short record of mixed values.
    add_row(-16'sd32768, 1'b1, 1'b1, 1, '0, 1'b1);
    add_row(16'sd32767, 1'b0, 1'b1, 0, '0, 1'b0);
    add_row(16'sd0, 1'b0, 1'b1, 0, '0, 1'b0);
    add_row(-16'sd1, 1'b1, 1'b1, 1, '0, 1'b1);
    // A record of exactly eight samples at the negative extreme.
    for (i = 0; i < HALF; i++)
      add_row(-16'sd32768, i == HALF - 1, 1'b1, (i == HALF - 1) ? HALF : 0,
              20'h80000, 1'b0);
    // Nine samples at the positive extreme: one mean, then the whole tail.
    for (i = 0; i <= HALF; i++)
      add_row(16'sd32767, i == HALF, 1'b1, (i == HALF) ? HALF + 1 : 0,
              20'h7FFF0, 1'b0);
    add_row(16'sd100, 1'b0, 1'b0, 0, '0, 1'b0);
    add_row(-16'sd200, 1'b0, 1'b0, 0, '0, 1'b0);
    add_row(16'sd300, 1'b0, 1'b0, 0, '0, 1'b0);
    add_row(-16'sd400, 1'b1, 1'b0, 0, '0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idx = 0;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i], (idx / 40) % 2 == 0);
      idx++;
    end

    rnd_count = 0;
    rec_left  = 0;
    while (rnd_count < RANDOM_ITEMS || rec_left != 0) begin
      if (rec_left == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: rec_left = $urandom_range(1, HALF - 1);
          1: rec_left = HALF;
          2: rec_left = HALF + 1;
          3: rec_left = $urandom_range(60, 120);
          default: rec_left = $urandom_range(10, 30);
        endcase
        // The final record ends with the random part.
        if (rec_left > RANDOM_ITEMS - rnd_count) rec_left = RANDOM_ITEMS - rnd_count;
      end
      pick = $urandom_range(0, 7);
      case (pick)
        0: r.sample = 16'sh7FFF;
        1: r.sample = 16'sh8000;
        2: r.sample = SAMPLE_BITS'($urandom_range(0, 15) - 8);
        default: r.sample = SAMPLE_BITS'($urandom);
      endcase
      r.last    = (rec_left == 1);
      r.typed   = 1'b0;
      r.n_means = 0;
      r.mean    = '0;
      r.shrt    = 1'b0;
      calm      = (rnd_count >= CALM_FROM);
      send_item(r, !calm && ((idx / 40) % 2 == 0));
      rec_left--;
      rnd_count++;
      idx++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("PASS mirrored_moving_average_17_core");
    end else begin
      $display("FAIL mirrored_moving_average_17_core");
    end
    $finish;
  end

endmodule
